>>> rtl/risc_memory_branch_execute_assert.svh
// assertion macros for the execute block
`ifndef RISC_MEMORY_BRANCH_EXECUTE_ASSERT_SVH
`define RISC_MEMORY_BRANCH_EXECUTE_ASSERT_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define RME_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rme assertion failed");
// property checked on every edge, reset included
`define RME_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rme assertion failed");
`else
`define RME_ASSERT(lbl, clk, rstn, prop)
`define RME_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/rme_pkg.sv
`default_nettype none

package rme_pkg;

  // default sizes
  localparam int unsigned DATA_BYTES_DEF  = 65536;
  localparam int unsigned STACK_BYTES_DEF = 4096;
  localparam int unsigned REG_COUNT_DEF   = 32;

  // stack pointer configuration
  localparam int unsigned CFG_W = 12;
  localparam logic [CFG_W-1:0] SP_RESET = 12'd4095;

  // stream widths
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 4;

  // opcodes
  localparam logic [7:0] OP_END    = 8'h00;
  localparam logic [7:0] OP_LOAD   = 8'h10;
  localparam logic [7:0] OP_STORE  = 8'h11;
  localparam logic [7:0] OP_FLOAD  = 8'h12;
  localparam logic [7:0] OP_FSTORE = 8'h13;
  localparam logic [7:0] OP_PUSH   = 8'h20;
  localparam logic [7:0] OP_POP    = 8'h21;
  localparam logic [7:0] OP_MOV1   = 8'h30;
  localparam logic [7:0] OP_MOV2   = 8'h31;
  localparam logic [7:0] OP_FMOV1  = 8'h32;
  localparam logic [7:0] OP_FMOV2  = 8'h33;
  localparam logic [7:0] OP_JUMP   = 8'h70;
  localparam logic [7:0] OP_BEQ    = 8'h80;
  localparam logic [7:0] OP_BNE    = 8'h81;
  localparam logic [7:0] OP_BLT    = 8'h82;
  localparam logic [7:0] OP_BGE    = 8'h83;
  localparam logic [7:0] OP_CALL   = 8'h90;
  localparam logic [7:0] OP_RET    = 8'h91;
  localparam logic [7:0] OP_DRAW   = 8'ha0;

  // request to a byte-banked word memory
  typedef struct packed {
    logic clr;
    logic wr;
    logic rd;
  } mem_req_t;

  // register number inside the implemented file
  function automatic logic reg_ok(logic [4:0] r, int unsigned count);
    return 32'(r) < count;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rme_regfile.sv
`default_nettype none

module rme_regfile #(
  parameter int unsigned REG_COUNT = rme_pkg::REG_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rd_en_i,
  input  wire logic [4:0]  rd_addr_a_i,
  input  wire logic [4:0]  rd_addr_b_i,
  output logic      [31:0] rd_data_a_o,
  output logic      [31:0] rd_data_b_o,
  input  wire logic        wr_en_i,
  input  wire logic [4:0]  wr_addr_i,
  input  wire logic [31:0] wr_data_i
);

  localparam int unsigned RIW = $clog2(REG_COUNT);

  logic [31:0]          rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [RIW-1:0]       wr_idx, a_idx, b_idx;
  logic                 wr_ok, a_ok, b_ok;

  // index and range
  always_comb begin
    wr_idx = RIW'(wr_addr_i);
    a_idx  = RIW'(rd_addr_a_i);
    b_idx  = RIW'(rd_addr_b_i);
    wr_ok  = wr_en_i && rme_pkg::reg_ok(wr_addr_i, REG_COUNT);
    a_ok   = rme_pkg::reg_ok(rd_addr_a_i, REG_COUNT);
    b_ok   = rme_pkg::reg_ok(rd_addr_b_i, REG_COUNT);
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      rf_mem[wr_idx] <= wr_data_i;
    end
  end

  // written marks, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // registered reads, write data passes through on a matching address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (!a_ok) begin
        rd_data_a_o <= '0;
      end else if (wr_ok && (wr_addr_i == rd_addr_a_i)) begin
        rd_data_a_o <= wr_data_i;
      end else if (valid_q[a_idx]) begin
        rd_data_a_o <= rf_mem[a_idx];
      end else begin
        rd_data_a_o <= '0;
      end
      if (!b_ok) begin
        rd_data_b_o <= '0;
      end else if (wr_ok && (wr_addr_i == rd_addr_b_i)) begin
        rd_data_b_o <= wr_data_i;
      end else if (valid_q[b_idx]) begin
        rd_data_b_o <= rf_mem[b_idx];
      end else begin
        rd_data_b_o <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rme_word_mem.sv
`default_nettype none

// four byte banks so that an unaligned little-endian word is one access
module rme_word_mem #(
  parameter int unsigned BYTES = rme_pkg::DATA_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire rme_pkg::mem_req_t             req_i,
  input  wire logic [$clog2(BYTES)-3:0]      clr_row_i,
  input  wire logic [$clog2(BYTES)-1:0]      addr_i,
  input  wire logic [31:0]                   wdata_i,
  output logic      [31:0]                   rdata_o
);

  localparam int unsigned AW   = $clog2(BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = BYTES / 4;

  logic [1:0]    off, off_q;
  logic [RW-1:0] row;
  logic [7:0]    bank_q [4];

  assign off = addr_i[1:0];
  assign row = addr_i[AW-1:2];

  // one bank per byte lane
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    bank_mem [ROWS];
    logic [RW-1:0] bank_row;
    logic [1:0]    lane;

    // banks below the start offset take the next row
    always_comb begin
      bank_row = (2'(b) < off) ? RW'(row + RW'(1)) : row;
      lane     = 2'(2'(b) - off);
    end

    always_ff @(posedge clk_i) begin
      if (req_i.clr) begin
        bank_mem[clr_row_i] <= '0;
      end else if (req_i.wr) begin
        bank_mem[bank_row] <= wdata_i[{lane, 3'b000} +: 8];
      end
      if (req_i.rd) begin
        bank_q[b] <= bank_mem[bank_row];
      end
    end
  end

  // offset of the last read
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      off_q <= off;
    end
  end

  // rotate the banks back into word order
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata_o[8*k +: 8] = bank_q[2'(off_q + 2'(k))];
    end
  end

endmodule

`default_nettype wire

>>> rtl/risc_memory_branch_execute.sv
`default_nettype none

// channel   dir  payload
// s_axis    in   tdata: req_type, reg_first, reg_second, imm_word, pc
// m_axis    out  tdata: next_pc; tuser: halt, draw_request, unsupported, mem_fault
// cfg       in   cfg_wdata_i loads the stack pointer
//
// two stages: an input register with the register file read, then the result
// register with the data and stack memory read; an item enters every cycle
// unless the output stalls, and its result is presented from the result register.
// after reset the data memory is cleared one row of four bytes per cycle,
// DATA_BYTES/4 rows (16384 at default size); s_axis_tready stays low then.
// a stalled output holds the result; the input stage still takes one item.
module risc_memory_branch_execute #(
  parameter int unsigned DATA_BYTES  = rme_pkg::DATA_BYTES_DEF,
  parameter int unsigned STACK_BYTES = rme_pkg::STACK_BYTES_DEF,
  parameter int unsigned REG_COUNT   = rme_pkg::REG_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // req_type[7:0] reg_first[12:8] reg_second[17:13] imm_word[49:18] pc[81:50]
  input  wire logic [rme_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // next_pc[31:0]
  output logic      [rme_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // halt[0] draw_request[1] unsupported[2] mem_fault[3]
  output logic      [rme_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_we_i,
  input  wire logic [rme_pkg::CFG_W-1:0]      cfg_wdata_i
);

  `include "risc_memory_branch_execute_assert.svh"

  localparam int unsigned DAW       = $clog2(DATA_BYTES);
  localparam int unsigned DRW       = DAW - 2;
  localparam int unsigned DATA_ROWS = DATA_BYTES / 4;
  localparam int unsigned SAW       = $clog2(STACK_BYTES);
  localparam int unsigned SPW       = ((SAW > rme_pkg::CFG_W) ? SAW : rme_pkg::CFG_W) + 1;
  localparam logic [31:0]    DATA_LIM  = 32'(DATA_BYTES - 4);
  localparam logic [SPW-1:0] STACK_LIM = SPW'(STACK_BYTES - 4);
  localparam logic [DRW-1:0] LAST_ROW  = DRW'(DATA_ROWS - 1);

  typedef enum logic [1:0] {SRC_VAL, SRC_DATA, SRC_STACK} wsrc_e;

  // handshake and clearing
  logic           accept, adv1;
  logic           clr_done_q;
  logic [DRW-1:0] clr_row_q;

  // input stage
  logic        v1_q;
  logic [7:0]  op1_q;
  logic [4:0]  ra1_q, rb1_q;
  logic [31:0] imm1_q, pc1_q;
  logic [31:0] rf_a, rf_b, ra_fw, rb_fw;

  // stack pointer, minus one is kept as all ones
  logic [SPW-1:0] sp_q, sp_d;
  logic [SPW:0]   sp_ext, push_a, pop_a;
  logic           push_fits, pop_fits, d_fits;

  // decode results
  logic [31:0]    npc, val, smem_wdata;
  logic           halt, draw, unsup, fault, wr, npc_stk;
  wsrc_e          src;
  logic           dmem_wr, dmem_rd, smem_wr, smem_rd, take;
  logic [SAW-1:0] smem_addr;

  // result stage
  logic        v2_q, npc_stk2_q, halt2_q, draw2_q, unsup2_q, fault2_q, wr2_q;
  logic [31:0] npc2_q, val2_q, s2_wdata;
  logic [4:0]  wreg2_q;
  wsrc_e       src2_q;

  // memories
  rme_pkg::mem_req_t dmem_req, smem_req;
  logic [31:0]       dmem_rdata, smem_rdata;

  assign adv1          = v1_q && (!v2_q || m_axis_tready);
  assign s_axis_tready = clr_done_q && (!v1_q || adv1);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // data memory clearing after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_row_q == LAST_ROW) begin
        clr_done_q <= 1'b1;
      end else begin
        clr_row_q <= DRW'(clr_row_q + DRW'(1));
      end
    end
  end

  // register file, read on acceptance
  rme_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (s_axis_tdata[12:8]),
    .rd_addr_b_i (s_axis_tdata[17:13]),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b),
    .wr_en_i     (v2_q && wr2_q),
    .wr_addr_i   (wreg2_q),
    .wr_data_i   (s2_wdata)
  );

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (adv1) begin
      v1_q <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op1_q  <= s_axis_tdata[7:0];
      ra1_q  <= s_axis_tdata[12:8];
      rb1_q  <= s_axis_tdata[17:13];
      imm1_q <= s_axis_tdata[49:18];
      pc1_q  <= s_axis_tdata[81:50];
    end
  end

  // value the result stage writes back
  always_comb begin
    case (src2_q)
      SRC_DATA:  s2_wdata = dmem_rdata;
      SRC_STACK: s2_wdata = smem_rdata;
      default:   s2_wdata = val2_q;
    endcase
  end

  // forward the item ahead
  always_comb begin
    ra_fw = (v2_q && wr2_q && (wreg2_q == ra1_q)) ? s2_wdata : rf_a;
    rb_fw = (v2_q && wr2_q && (wreg2_q == rb1_q)) ? s2_wdata : rf_b;
  end

  // address checks
  always_comb begin
    sp_ext    = {sp_q[SPW-1], sp_q};
    push_a    = (SPW+1)'(sp_ext - (SPW+1)'(3));
    pop_a     = (SPW+1)'(sp_ext + (SPW+1)'(1));
    push_fits = !push_a[SPW] && (push_a[SPW-1:0] <= STACK_LIM);
    pop_fits  = !pop_a[SPW] && (pop_a[SPW-1:0] <= STACK_LIM);
    d_fits    = rb_fw <= DATA_LIM;
  end

  // instruction decode
  always_comb begin
    npc        = pc1_q;
    halt       = 1'b0;
    draw       = 1'b0;
    unsup      = 1'b0;
    fault      = 1'b0;
    wr         = 1'b0;
    src        = SRC_VAL;
    val        = rb_fw;
    npc_stk    = 1'b0;
    dmem_wr    = 1'b0;
    dmem_rd    = 1'b0;
    smem_wr    = 1'b0;
    smem_rd    = 1'b0;
    sp_d       = sp_q;
    smem_addr  = pop_a[SAW-1:0];
    smem_wdata = ra_fw;
    take       = 1'b0;
    unique case (op1_q) inside
      rme_pkg::OP_LOAD, rme_pkg::OP_FLOAD: begin
        npc = pc1_q + 32'd3;
        if (d_fits) begin
          dmem_rd = 1'b1;
          wr      = 1'b1;
          src     = SRC_DATA;
        end else begin
          fault = 1'b1;
        end
      end
      rme_pkg::OP_STORE, rme_pkg::OP_FSTORE: begin
        npc = pc1_q + 32'd3;
        if (d_fits) begin
          dmem_wr = 1'b1;
        end else begin
          fault = 1'b1;
        end
      end
      rme_pkg::OP_PUSH: begin
        npc       = pc1_q + 32'd2;
        smem_addr = push_a[SAW-1:0];
        if (push_fits) begin
          smem_wr = 1'b1;
          sp_d    = SPW'(sp_ext - (SPW+1)'(4));
        end else begin
          fault = 1'b1;
        end
      end
      rme_pkg::OP_POP: begin
        npc = pc1_q + 32'd2;
        if (pop_fits) begin
          smem_rd = 1'b1;
          wr      = 1'b1;
          src     = SRC_STACK;
          sp_d    = SPW'(sp_ext + (SPW+1)'(4));
        end else begin
          fault = 1'b1;
        end
      end
      rme_pkg::OP_MOV1, rme_pkg::OP_FMOV1: begin
        npc = pc1_q + 32'd3;
        wr  = 1'b1;
      end
      rme_pkg::OP_MOV2, rme_pkg::OP_FMOV2: begin
        npc = pc1_q + 32'd6;
        wr  = 1'b1;
        val = imm1_q;
      end
      rme_pkg::OP_JUMP: begin
        npc = imm1_q;
      end
      rme_pkg::OP_BEQ, rme_pkg::OP_BNE, rme_pkg::OP_BLT, rme_pkg::OP_BGE: begin
        case (op1_q)
          rme_pkg::OP_BEQ: take = ra_fw == rb_fw;
          rme_pkg::OP_BNE: take = ra_fw != rb_fw;
          rme_pkg::OP_BLT: take = $signed(ra_fw) < $signed(rb_fw);
          default:         take = $signed(ra_fw) >= $signed(rb_fw);
        endcase
        npc = take ? imm1_q : pc1_q + 32'd7;
      end
      rme_pkg::OP_CALL: begin
        npc        = imm1_q;
        smem_addr  = push_a[SAW-1:0];
        smem_wdata = pc1_q + 32'd5;
        if (push_fits) begin
          smem_wr = 1'b1;
          sp_d    = SPW'(sp_ext - (SPW+1)'(4));
        end else begin
          fault = 1'b1;
        end
      end
      rme_pkg::OP_RET: begin
        if (pop_fits) begin
          smem_rd = 1'b1;
          npc_stk = 1'b1;
          sp_d    = SPW'(sp_ext + (SPW+1)'(4));
        end else begin
          fault = 1'b1;
          npc   = pc1_q + 32'd1;
        end
      end
      rme_pkg::OP_DRAW: begin
        draw = 1'b1;
        npc  = pc1_q + 32'd1;
      end
      rme_pkg::OP_END: begin
        halt = 1'b1;
      end
      default: begin
        unsup = 1'b1;
      end
    endcase
    // writes beyond the file are dropped, and must not be forwarded
    wr = wr && rme_pkg::reg_ok(ra1_q, REG_COUNT);
  end

  // stack pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= SPW'(rme_pkg::SP_RESET);
    end else if (cfg_we_i) begin
      sp_q <= SPW'(cfg_wdata_i);
    end else if (adv1) begin
      sp_q <= sp_d;
    end
  end

  // memory requests, issued as the item moves to the result stage
  always_comb begin
    dmem_req.clr = !clr_done_q;
    dmem_req.wr  = adv1 && dmem_wr;
    dmem_req.rd  = adv1 && dmem_rd;
    smem_req.clr = 1'b0;
    smem_req.wr  = adv1 && smem_wr;
    smem_req.rd  = adv1 && smem_rd;
  end

  rme_word_mem #(
    .BYTES (DATA_BYTES)
  ) u_data_mem (
    .clk_i     (clk_i),
    .req_i     (dmem_req),
    .clr_row_i (clr_row_q),
    .addr_i    (rb_fw[DAW-1:0]),
    .wdata_i   (ra_fw),
    .rdata_o   (dmem_rdata)
  );

  rme_word_mem #(
    .BYTES (STACK_BYTES)
  ) u_stack_mem (
    .clk_i     (clk_i),
    .req_i     (smem_req),
    .clr_row_i ('0),
    .addr_i    (smem_addr),
    .wdata_i   (smem_wdata),
    .rdata_o   (smem_rdata)
  );

  // result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv1) begin
      v2_q <= 1'b1;
    end else if (m_axis_tready) begin
      v2_q <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      npc2_q     <= npc;
      npc_stk2_q <= npc_stk;
      halt2_q    <= halt;
      draw2_q    <= draw;
      unsup2_q   <= unsup;
      fault2_q   <= fault;
      wr2_q      <= wr;
      wreg2_q    <= ra1_q;
      src2_q     <= src;
      val2_q     <= val;
    end
  end

  // result item
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = npc_stk2_q ? smem_rdata : npc2_q;
  assign m_axis_tuser  = {fault2_q, unsup2_q, draw2_q, halt2_q};

  // no item in flight during the clearing pass
  `RME_ASSERT_ALWAYS(a_clear_idle, clk_i, (!clr_done_q |-> (!v1_q && !v2_q)))
  // at most one flag per result
  `RME_ASSERT(a_flags_onehot, clk_i, rst_ni,
              (v2_q |-> $onehot0({halt2_q, draw2_q, unsup2_q, fault2_q})))
  // unsupported opcodes leave the register file alone
  `RME_ASSERT(a_unsup_no_write, clk_i, rst_ni, ((v2_q && unsup2_q) |-> !wr2_q))
  // a blocked input stage keeps its item
  `RME_ASSERT(a_s1_hold, clk_i, rst_ni,
              ((v1_q && v2_q && !m_axis_tready && !cfg_we_i) |=> (v1_q && $stable(pc1_q))))
  // the stack pointer never drops below minus one
  `RME_ASSERT(a_sp_floor, clk_i, rst_ni, (sp_q[SPW-1] |-> (&sp_q)))

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;

  localparam int unsigned DATA_SIZE   = rme_pkg::DATA_BYTES_DEF;
  localparam int unsigned STACK_SIZE  = rme_pkg::STACK_BYTES_DEF;
  localparam int unsigned IDLE_LIMIT  = 100000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 115;

  // one decoded instruction
  typedef struct packed {
    logic [7:0]  req_type;
    logic [4:0]  reg_first;
    logic [4:0]  reg_second;
    logic [31:0] imm_word;
    logic [31:0] pc;
  } instr_t;

  // next pc and flags of one instruction
  typedef struct packed {
    logic [31:0] next_pc;
    logic        halt;
    logic        draw_request;
    logic        unsupported;
    logic        mem_fault;
  } outcome_t;

  typedef struct packed {
    instr_t   instr;
    logic     typed;
    outcome_t outcome;
  } dir_row_t;

  localparam outcome_t NO_OUTCOME = '{32'h0, 1'b0, 1'b0, 1'b0, 1'b0};

  // directed items, run with the stack pointer at its reset value
  localparam int unsigned DIR_COUNT = 27;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // registers and data memory read as zero after reset
    '{'{rme_pkg::OP_LOAD, 5'd1, 5'd0, 32'h0, 32'h0}, 1'b1,
      '{32'h3, 1'b0, 1'b0, 1'b0, 1'b0}},
    // empty stack: pop and ret fault, ret steps by one
    '{'{rme_pkg::OP_POP, 5'd2, 5'd0, 32'h0, 32'd100}, 1'b1,
      '{32'd102, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{rme_pkg::OP_RET, 5'd31, 5'd31, 32'hffffffff, 32'hffffffff}, 1'b1,
      '{32'h0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{rme_pkg::OP_END, 5'd31, 5'd31, 32'hffffffff, 32'hffffffff}, 1'b1,
      '{32'hffffffff, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{rme_pkg::OP_DRAW, 5'd0, 5'd0, 32'h0, 32'h10}, 1'b1,
      '{32'h11, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{8'hff, 5'd31, 5'd31, 32'hffffffff, 32'hdeadbeef}, 1'b1,
      '{32'hdeadbeef, 1'b0, 1'b0, 1'b1, 1'b0}},
    // pc wraps past the top
    '{'{rme_pkg::OP_MOV2, 5'd1, 5'd0, 32'hffffffff, 32'hfffffffc}, 1'b1,
      '{32'h2, 1'b0, 1'b0, 1'b0, 1'b0}},
    // address far outside the data memory
    '{'{rme_pkg::OP_LOAD, 5'd2, 5'd1, 32'h0, 32'h20}, 1'b1,
      '{32'h23, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{rme_pkg::OP_MOV2, 5'd3, 5'd0, 32'd65532, 32'h0}, 1'b1,
      '{32'h6, 1'b0, 1'b0, 1'b0, 1'b0}},
    // last word that fits
    '{'{rme_pkg::OP_STORE, 5'd1, 5'd3, 32'h0, 32'h0}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_LOAD, 5'd4, 5'd3, 32'h0, 32'h0}, 1'b0, NO_OUTCOME},
    // word reaching one byte past the end
    '{'{rme_pkg::OP_MOV2, 5'd5, 5'd0, 32'd65533, 32'h0}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_STORE, 5'd1, 5'd5, 32'h0, 32'h0}, 1'b1,
      '{32'h3, 1'b0, 1'b0, 1'b0, 1'b1}},
    // unaligned word, float forms as plain copies
    '{'{rme_pkg::OP_MOV2, 5'd6, 5'd0, 32'd1, 32'h100}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_FMOV2, 5'd9, 5'd0, 32'h80000000, 32'h200}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_FSTORE, 5'd9, 5'd6, 32'h0, 32'h300}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_FLOAD, 5'd10, 5'd0, 32'h0, 32'h400}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_MOV1, 5'd11, 5'd9, 32'h0, 32'h500}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_FMOV1, 5'd12, 5'd1, 32'h0, 32'h600}, 1'b0, NO_OUTCOME},
    // signed compare of the most negative value against minus one
    '{'{rme_pkg::OP_BLT, 5'd9, 5'd1, 32'h40000000, 32'h700}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_BGE, 5'd9, 5'd1, 32'h40000000, 32'hfffffffc}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_BEQ, 5'd11, 5'd9, 32'h12345678, 32'h800}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_JUMP, 5'd0, 5'd0, 32'hffffffff, 32'ha00}, 1'b1,
      '{32'hffffffff, 1'b0, 1'b0, 1'b0, 1'b0}},
    // push, call with wrapping return address, then unwind
    '{'{rme_pkg::OP_PUSH, 5'd12, 5'd0, 32'h0, 32'hb00}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_CALL, 5'd0, 5'd0, 32'h1000, 32'hfffffffe}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_RET, 5'd0, 5'd0, 32'h0, 32'h1000}, 1'b0, NO_OUTCOME},
    '{'{rme_pkg::OP_POP, 5'd13, 5'd0, 32'h0, 32'hc00}, 1'b0, NO_OUTCOME}
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic [rme_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rme_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [rme_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [rme_pkg::CFG_W-1:0]      cfg_wdata_i   = '0;

  risc_memory_branch_execute i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // machine state as the block should hold it
  logic [31:0] gpr [32];
  logic [7:0]  data_bytes [DATA_SIZE];
  logic [7:0]  stack_bytes [STACK_SIZE];
  bit          stack_written [STACK_SIZE];
  logic [31:0] stack_ptr;

  outcome_t    pending_outcomes [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;

  function automatic logic word_fits(logic [31:0] a, int unsigned size);
    return (a < size) && ((size - a) >= 32'd4);
  endfunction

  // word onto the stack: bytes sp-3..sp, then sp moves down
  function automatic logic push_word(logic [31:0] v);
    logic [31:0] a;
    a = stack_ptr - 32'd3;
    if (!word_fits(a, STACK_SIZE)) return 1'b0;
    for (int i = 0; i < 4; i++) begin
      stack_bytes[a + i]   = v[8*i +: 8];
      stack_written[a + i] = 1'b1;
    end
    stack_ptr = stack_ptr - 32'd4;
    return 1'b1;
  endfunction

  // word off the stack: bytes sp+1..sp+4, then sp moves up
  function automatic logic pop_word(output logic [31:0] v);
    logic [31:0] a;
    a = stack_ptr + 32'd1;
    v = '0;
    if (!word_fits(a, STACK_SIZE)) return 1'b0;
    v = {stack_bytes[a + 3], stack_bytes[a + 2], stack_bytes[a + 1], stack_bytes[a]};
    stack_ptr = stack_ptr + 32'd4;
    return 1'b1;
  endfunction

  // execute one instruction on the shadow state
  function automatic outcome_t execute_instr(instr_t it);
    outcome_t    o;
    logic [31:0] a;
    logic [31:0] v;
    logic        take;
    o = NO_OUTCOME;
    o.next_pc = it.pc;
    case (it.req_type)
      rme_pkg::OP_LOAD, rme_pkg::OP_FLOAD: begin
        a = gpr[it.reg_second];
        if (word_fits(a, DATA_SIZE))
          gpr[it.reg_first] = {data_bytes[a + 3], data_bytes[a + 2],
                               data_bytes[a + 1], data_bytes[a]};
        else
          o.mem_fault = 1'b1;
        o.next_pc = it.pc + 32'd3;
      end
      rme_pkg::OP_STORE, rme_pkg::OP_FSTORE: begin
        a = gpr[it.reg_second];
        v = gpr[it.reg_first];
        if (word_fits(a, DATA_SIZE)) begin
          for (int i = 0; i < 4; i++) data_bytes[a + i] = v[8*i +: 8];
        end else begin
          o.mem_fault = 1'b1;
        end
        o.next_pc = it.pc + 32'd3;
      end
      rme_pkg::OP_PUSH: begin
        if (!push_word(gpr[it.reg_first])) o.mem_fault = 1'b1;
        o.next_pc = it.pc + 32'd2;
      end
      rme_pkg::OP_POP: begin
        if (pop_word(v)) gpr[it.reg_first] = v;
        else o.mem_fault = 1'b1;
        o.next_pc = it.pc + 32'd2;
      end
      rme_pkg::OP_MOV1, rme_pkg::OP_FMOV1: begin
        gpr[it.reg_first] = gpr[it.reg_second];
        o.next_pc = it.pc + 32'd3;
      end
      rme_pkg::OP_MOV2, rme_pkg::OP_FMOV2: begin
        gpr[it.reg_first] = it.imm_word;
        o.next_pc = it.pc + 32'd6;
      end
      rme_pkg::OP_JUMP: o.next_pc = it.imm_word;
      rme_pkg::OP_BEQ, rme_pkg::OP_BNE, rme_pkg::OP_BLT, rme_pkg::OP_BGE: begin
        a = gpr[it.reg_first];
        v = gpr[it.reg_second];
        case (it.req_type)
          rme_pkg::OP_BEQ: take = (a == v);
          rme_pkg::OP_BNE: take = (a != v);
          rme_pkg::OP_BLT: take = ($signed(a) < $signed(v));
          default:         take = ($signed(a) >= $signed(v));
        endcase
        o.next_pc = take ? it.imm_word : it.pc + 32'd7;
      end
      rme_pkg::OP_CALL: begin
        // the jump happens even when the return address cannot be saved
        if (!push_word(it.pc + 32'd5)) o.mem_fault = 1'b1;
        o.next_pc = it.imm_word;
      end
      rme_pkg::OP_RET: begin
        if (pop_word(v)) begin
          o.next_pc = v;
        end else begin
          o.mem_fault = 1'b1;
          o.next_pc = it.pc + 32'd1;
        end
      end
      rme_pkg::OP_DRAW: begin
        o.draw_request = 1'b1;
        o.next_pc = it.pc + 32'd1;
      end
      rme_pkg::OP_END: o.halt = 1'b1;
      default: o.unsupported = 1'b1;
    endcase
    return o;
  endfunction

  // mostly well-formed programs: address registers r24..r31 point into memory
  function automatic instr_t random_instr();
    instr_t      it;
    int unsigned pick;
    int unsigned zone;
    logic [31:0] a;
    it.req_type   = 8'($urandom());
    it.reg_first  = 5'($urandom());
    it.reg_second = 5'($urandom());
    it.imm_word   = $urandom();
    it.pc         = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      it.req_type  = $urandom_range(0, 1) ? rme_pkg::OP_MOV2 : rme_pkg::OP_FMOV2;
      it.reg_first = 5'($urandom_range(24, 31));
      zone = $urandom_range(0, 9);
      if (zone < 6) it.imm_word = $urandom_range(0, 64);
      else if (zone < 9) it.imm_word = $urandom_range(DATA_SIZE - 12, DATA_SIZE - 1);
    end else if (pick < 38) begin
      case ($urandom_range(0, 3))
        0:       it.req_type = rme_pkg::OP_LOAD;
        1:       it.req_type = rme_pkg::OP_STORE;
        2:       it.req_type = rme_pkg::OP_FLOAD;
        default: it.req_type = rme_pkg::OP_FSTORE;
      endcase
      if ($urandom_range(0, 4) != 0) it.reg_second = 5'($urandom_range(24, 31));
    end else if (pick < 58) begin
      zone = $urandom_range(0, 19);
      if (zone < 8) it.req_type = rme_pkg::OP_PUSH;
      else if (zone < 14) it.req_type = rme_pkg::OP_POP;
      else if (zone < 17) it.req_type = rme_pkg::OP_CALL;
      else it.req_type = rme_pkg::OP_RET;
    end else if (pick < 64) begin
      case ($urandom_range(0, 3))
        0:       it.req_type = rme_pkg::OP_MOV1;
        1:       it.req_type = rme_pkg::OP_FMOV1;
        2:       it.req_type = rme_pkg::OP_MOV2;
        default: it.req_type = rme_pkg::OP_FMOV2;
      endcase
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0:       it.req_type = rme_pkg::OP_BEQ;
        1:       it.req_type = rme_pkg::OP_BNE;
        2:       it.req_type = rme_pkg::OP_BLT;
        default: it.req_type = rme_pkg::OP_BGE;
      endcase
      if ($urandom_range(0, 2) == 0) it.reg_second = it.reg_first;
    end else if (pick < 88) begin
      case ($urandom_range(0, 2))
        0:       it.req_type = rme_pkg::OP_JUMP;
        1:       it.req_type = rme_pkg::OP_DRAW;
        default: it.req_type = rme_pkg::OP_END;
      endcase
    end
    // stack bytes never written must not be read: turn such a read into a write
    if (it.req_type == rme_pkg::OP_POP || it.req_type == rme_pkg::OP_RET) begin
      a = stack_ptr + 32'd1;
      if (word_fits(a, STACK_SIZE) &&
          !(stack_written[a] && stack_written[a + 1] &&
            stack_written[a + 2] && stack_written[a + 3]))
        it.req_type = (it.req_type == rme_pkg::OP_POP) ? rme_pkg::OP_PUSH
                                                       : rme_pkg::OP_CALL;
    end
    return it;
  endfunction

  // predict, then offer the item until it is taken; returns at a falling edge
  task automatic send_instr(input instr_t it, input logic typed, input outcome_t fixed);
    outcome_t    predicted;
    int unsigned gap;
    predicted = execute_instr(it);
    pending_outcomes.push_back(typed ? fixed : predicted);
    // idle gap between bursts
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  <= {6'b0, it.pc, it.imm_word, it.reg_second, it.reg_first, it.req_type};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stalls, with a stall pattern that is picked anew now and then
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned rx_cycles  = 0;
  always @(negedge clk_i) begin
    if (rx_cycles % 300 == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        default: stall_pct = 60;
      endcase
    end
    rx_cycles++;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin : monitor
    outcome_t got;
    outcome_t want;
    if (m_axis_tvalid && m_axis_tready && rst_ni) begin
      got.next_pc      = m_axis_tdata;
      got.halt         = m_axis_tuser[0];
      got.draw_request = m_axis_tuser[1];
      got.unsupported  = m_axis_tuser[2];
      got.mem_fault    = m_axis_tuser[3];
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: next_pc %h flags %b", got.next_pc, m_axis_tuser);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.next_pc !== want.next_pc || got.halt !== want.halt ||
            got.draw_request !== want.draw_request ||
            got.unsupported !== want.unsupported || got.mem_fault !== want.mem_fault) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected next_pc %h halt %b draw %b unsup %b fault %b",
                     want.next_pc, want.halt, want.draw_request, want.unsupported,
                     want.mem_fault);
            $display("          got next_pc %h halt %b draw %b unsup %b fault %b",
                     got.next_pc, got.halt, got.draw_request, got.unsupported,
                     got.mem_fault);
          end
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  logic [rme_pkg::CFG_W-1:0] phase_tops [PHASES];

  initial begin
    foreach (gpr[i]) gpr[i] = 32'h0;
    foreach (data_bytes[i]) data_bytes[i] = 8'h00;
    foreach (stack_written[i]) stack_written[i] = 1'b0;
    stack_ptr = 32'(rme_pkg::SP_RESET);
    phase_tops = '{rme_pkg::SP_RESET, 12'd3, 12'd0, 12'hfff, 12'd2048,
                   12'($urandom_range(4, 4094)), 12'($urandom())};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      // drain the pipeline before moving the stack pointer
      s_axis_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= phase_tops[ph];
      @(negedge clk_i);
      cfg_we_i  <= 1'b0;
      stack_ptr = 32'(phase_tops[ph]);
      if (ph == 0) begin
        foreach (DIR_ROWS[r])
          send_instr(DIR_ROWS[r].instr, DIR_ROWS[r].typed, DIR_ROWS[r].outcome);
      end else begin
        repeat (PHASE_ITEMS) send_instr(random_instr(), 1'b0, NO_OUTCOME);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
